/* sv/nv12_to_rgb_converter_assert.svh */
// ---------------------------------------------------------------------------
// NV12 to RGB converter assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is
// low. They compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef NV12_TO_RGB_CONVERTER_ASSERT_SVH
`define NV12_TO_RGB_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define N2R_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define N2R_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define N2R_ASSERT_IMP(lbl, ante, cons, msg)
`define N2R_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/n2r_pkg.sv */
// ---------------------------------------------------------------------------
// NV12 to RGB converter package
// Payload types, format codes and BT.601 limited-range coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

package n2r_pkg;

  // Sample and pixel widths.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned LANES    = 4;

  // Width of the signed intermediate sums; holds -70688..136882.
  localparam int unsigned SUM_W = 19;

  // Coefficients and offsets.
  localparam logic signed [SUM_W-1:0] C_Y      = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] C_R_V    = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] C_G_U    = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] C_G_V    = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] C_B_U    = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] ROUND    = SUM_W'(128);
  localparam logic signed [SUM_W-1:0] Y_OFFSET = SUM_W'(16);
  localparam logic signed [SAMPLE_W:0] C_OFFSET = (SAMPLE_W+1)'(128);

  // Output format codes.
  typedef enum logic {
    FMT_RGB888 = 1'b0,
    FMT_RGB565 = 1'b1
  } out_fmt_t;

  // One input transfer: a 2x2 block with its shared chroma pair.
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma_top_left;
    logic [SAMPLE_W-1:0] luma_top_right;
    logic [SAMPLE_W-1:0] luma_bottom_left;
    logic [SAMPLE_W-1:0] luma_bottom_right;
    logic [SAMPLE_W-1:0] chroma_u;
    logic [SAMPLE_W-1:0] chroma_v;
    logic [LANES-1:0]    lane_valid;
  } in_item_t;

  // One result transfer: four packed pixels and the valid mask.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_top_left;
    logic [PIXEL_W-1:0] pixel_top_right;
    logic [PIXEL_W-1:0] pixel_bottom_left;
    logic [PIXEL_W-1:0] pixel_bottom_right;
    logic [LANES-1:0]   pixel_valid;
  } out_item_t;

  // Chroma contributions shared by all four lanes.
  typedef struct packed {
    logic signed [SUM_W-1:0] r_term;
    logic signed [SUM_W-1:0] g_term;
    logic signed [SUM_W-1:0] b_term;
  } chroma_terms_t;

endpackage

`default_nettype wire

/* sv/n2r_lane.sv */
// ---------------------------------------------------------------------------
// NV12 to RGB converter pixel lane
// Converts one luma sample plus the shared chroma terms into a clamped,
// packed RGB888 or RGB565 pixel. Purely combinational.
// ---------------------------------------------------------------------------
`default_nettype none

module n2r_lane
  import n2r_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] luma,
  input  wire chroma_terms_t       terms,
  input  wire out_fmt_t            fmt,
  input  wire logic                lane_en,
  output logic [PIXEL_W-1:0]       pixel
);

  // Clamp a sum to 0..255 after dropping the eight fraction bits.
  function automatic logic [7:0] sat_channel(input logic signed [SUM_W-1:0] s);
    logic [7:0] v;
    if (s[SUM_W-1]) begin
      v = 8'h00;
    end else if (|s[SUM_W-2:16]) begin
      v = 8'hFF;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

  logic signed [SUM_W-1:0] luma_c;
  logic signed [SUM_W-1:0] base;
  logic [7:0]              red;
  logic [7:0]              green;
  logic [7:0]              blue;

  // Scaled luma with the rounding constant folded in.
  assign luma_c = signed'(SUM_W'(luma)) - Y_OFFSET;
  assign base   = luma_c * C_Y + ROUND;

  // Per-channel sums and clamping.
  assign red   = sat_channel(base + terms.r_term);
  assign green = sat_channel(base + terms.g_term);
  assign blue  = sat_channel(base + terms.b_term);

  // Pack into the selected format; an absent pixel reads as zero.
  always_comb begin
    pixel = '0;
    if (lane_en) begin
      case (fmt)
        FMT_RGB888: pixel = {red, green, blue};
        FMT_RGB565: pixel = {8'h00, red[7:3], green[7:2], blue[7:3]};
        default:    pixel = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/nv12_to_rgb_converter.sv */
// ---------------------------------------------------------------------------
// NV12 to RGB converter
// Converts one NV12 2x2 block per clock to RGB888 or RGB565 pixels using
// BT.601 limited-range integer math.
// ---------------------------------------------------------------------------
// Usage:
//   Input: a transfer happens at a rising edge with start high and busy low.
//   busy is high only for the first cycle after reset, so a block can be
//   offered in every cycle.
//   Output: out_valid is high for exactly one cycle with the result on
//   out_data; the receiver must take it in that cycle.
//   Path: the result of an accepted block passes the input register, then
//   the result register, before out_valid strobes it.
//   Throughput: one block per clock while busy is low, through the two
//   register stages; the four lanes run in parallel.
//   Configuration: cfg_wr_en writes cfg_wr_data into the output format
//   register (0 RGB888, 1 RGB565). Write it only while no block is in
//   flight.
//   Reset: rst_n low clears the valid flags of both stages and sets RGB888. Blocks in flight
//   are dropped. The receiver cannot stall, so there is no back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nv12_to_rgb_converter_assert.svh"

module nv12_to_rgb_converter
  import n2r_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // Input channel
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_data,
  // Result channel
  output logic          out_valid,
  output out_item_t     out_data,
  // Configuration
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data
);

  logic          busy_r;
  out_fmt_t      fmt_r;
  logic          in_valid_r;
  in_item_t      in_r;
  logic          out_valid_r;
  out_item_t     out_r;
  out_item_t     out_nxt;
  chroma_terms_t terms;
  logic signed [SAMPLE_W:0] d_s;
  logic signed [SAMPLE_W:0] e_s;
  logic signed [SUM_W-1:0]  d_ext;
  logic signed [SUM_W-1:0]  e_ext;
  logic [SAMPLE_W-1:0]      lane_luma [LANES];
  logic [PIXEL_W-1:0]       lane_pixel [LANES];
  logic                     in_fire;

  assign in_fire = start && !busy_r;
  assign busy    = busy_r;

  // Hold off input for the cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Output format register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB888;
    end else if (cfg_wr_en) begin
      fmt_r <= out_fmt_t'(cfg_wr_data);
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
  end

  // Shared chroma terms, computed once for all four lanes.
  assign d_s   = signed'({1'b0, in_r.chroma_u}) - C_OFFSET;
  assign e_s   = signed'({1'b0, in_r.chroma_v}) - C_OFFSET;
  assign d_ext = SUM_W'(d_s);
  assign e_ext = SUM_W'(e_s);

  assign terms.r_term = e_ext * C_R_V;
  assign terms.g_term = -(d_ext * C_G_U) - (e_ext * C_G_V);
  assign terms.b_term = d_ext * C_B_U;

  // Pixel lanes.
  assign lane_luma[0] = in_r.luma_top_left;
  assign lane_luma[1] = in_r.luma_top_right;
  assign lane_luma[2] = in_r.luma_bottom_left;
  assign lane_luma[3] = in_r.luma_bottom_right;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    n2r_lane u_lane (
      .luma    (lane_luma[k]),
      .terms   (terms),
      .fmt     (fmt_r),
      .lane_en (in_r.lane_valid[k]),
      .pixel   (lane_pixel[k])
    );
  end

  // Assemble the result.
  always_comb begin
    out_nxt.pixel_top_left     = lane_pixel[0];
    out_nxt.pixel_top_right    = lane_pixel[1];
    out_nxt.pixel_bottom_left  = lane_pixel[2];
    out_nxt.pixel_bottom_right = lane_pixel[3];
    out_nxt.pixel_valid        = in_r.lane_valid;
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every accepted block is strobed out after passing both register stages.
  `N2R_ASSERT_NXT(a_accept_to_result, in_fire, ##1 out_valid, "accepted block lost")
  // No result appears without a matching accepted block.
  `N2R_ASSERT_IMP(a_no_spurious, out_valid, $past(in_fire, 2), "result without block")
  // The valid mask travels unchanged with its block.
  `N2R_ASSERT_IMP(a_mask_copy, out_valid, out_data.pixel_valid == $past(in_data.lane_valid, 2), "valid mask corrupted")
  // Absent pixels read as zero.
  `N2R_ASSERT_IMP(a_zero_lanes, out_valid, (out_data.pixel_valid[0] || out_data.pixel_top_left == '0) && (out_data.pixel_valid[1] || out_data.pixel_top_right == '0) && (out_data.pixel_valid[2] || out_data.pixel_bottom_left == '0) && (out_data.pixel_valid[3] || out_data.pixel_bottom_right == '0), "absent pixel not zero")

endmodule

`default_nettype wire
